/* src/assert_macros.svh */
// Assertion macros for the interrupt controller RTL.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define MTIC_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define MTIC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/mtic_pkg.sv */
// Package for the multi-target interrupt controller.
// Holds sizes, register offsets, opcodes, item types and the sequencer states.
// No dependencies.
package mtic_pkg;

    localparam int TARGET_COUNT  = 4;
    localparam int TARGET_STRIDE = 32;

    localparam int ADDR_W   = 7;
    localparam int DATA_W   = 32;
    localparam int SRC_W    = 6;
    localparam int LINE_OUT = 4;
    localparam int TGT_W    = (TARGET_COUNT > 1) ? $clog2(TARGET_COUNT) : 1;
    localparam int WIDX_W   = TGT_W + 1;
    localparam int NUM_WORDS = 2 * TARGET_COUNT;
    localparam int OFF_W    = $clog2(TARGET_STRIDE);

    localparam logic [OFF_W-1:0] OFF_ENABLE0   = OFF_W'(0);
    localparam logic [OFF_W-1:0] OFF_ENABLE1   = OFF_W'(4);
    localparam logic [OFF_W-1:0] OFF_PEND0     = OFF_W'(8);
    localparam logic [OFF_W-1:0] OFF_PEND1     = OFF_W'(12);
    localparam logic [OFF_W-1:0] OFF_CLAIM     = OFF_W'(16);
    localparam logic [OFF_W-1:0] OFF_THRESHOLD = OFF_W'(20);

    localparam logic [SRC_W-1:0] SRC_FIRST = SRC_W'(1);
    localparam logic [SRC_W-1:0] SRC_LAST  = SRC_W'(63);

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_EVENT = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic [SRC_W-1:0]  irq_number;
        logic              line_level;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic                access_error;
        logic [LINE_OUT-1:0] target_irq_lines;
    } rsp_t;

endpackage

/* src/multi_target_interrupt_controller_top.sv */
// Top level of the multi-target interrupt controller: register file,
// claim scanner and sequencer. Uses mtic_pkg and assert_macros.svh.

// One item at a time. A read or write that needs no claim passes from acceptance
// through ST_EXEC and ST_DONE back to ST_IDLE. A claim read, or any write that is not
// rejected, adds a claim scan of one source per cycle, ending early at the first
// enabled pending source or at the target threshold. A raised source scans every
// target in turn. A finished result waits in an output register, so the next item
// is taken while it is still stalled.
`include "assert_macros.svh"

module multi_target_interrupt_controller_top
    import mtic_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    state_t state_reg, state_next;

    logic [DATA_W-1:0] pend_reg [NUM_WORDS];
    logic [DATA_W-1:0] pend_next[NUM_WORDS];
    logic [DATA_W-1:0] en_reg   [NUM_WORDS];
    logic [DATA_W-1:0] en_next  [NUM_WORDS];
    logic [SRC_W-1:0]  thr_reg  [TARGET_COUNT];
    logic [SRC_W-1:0]  thr_next [TARGET_COUNT];
    logic [TARGET_COUNT-1:0] line_reg, line_next;

    req_t              req_reg, req_next;
    logic [DATA_W-1:0] rd_reg, rd_next;
    logic              err_reg, err_next;
    logic [SRC_W-1:0]  src_reg, src_next;
    logic [TGT_W-1:0]  scan_t_reg, scan_t_next;
    logic              scan_all_reg, scan_all_next;
    logic              claim_rd_reg, claim_rd_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic [ADDR_W-1:0] exec_tgt_full;
    logic [OFF_W-1:0]  exec_off;
    logic [TGT_W-1:0]  exec_tgt;
    logic              tgt_ok;
    logic              data_big;
    logic              exec_err;
    logic              exec_scan;
    logic              exec_event;

    logic [TGT_W-1:0]  cur_tgt;
    logic              cur_sel;
    logic [WIDX_W-1:0] widx;
    logic [DATA_W-1:0] word_pe;
    logic [DATA_W-1:0] word_en;
    logic [DATA_W-1:0] word_act;
    logic [SRC_W-1:0]  thr_cur;

    logic              scan_fin;
    logic [SRC_W-1:0]  scan_claim;
    logic              scan_last;
    logic              rsp_load;

    logic [TARGET_COUNT+LINE_OUT-1:0] lines_ext;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // address decode of the held item
    assign exec_tgt_full = ADDR_W'(req_reg.address / TARGET_STRIDE);
    assign exec_off      = OFF_W'(req_reg.address % TARGET_STRIDE);
    assign tgt_ok        = (exec_tgt_full < ADDR_W'(TARGET_COUNT));
    assign exec_tgt      = exec_tgt_full[TGT_W-1:0];
    assign data_big      = |req_reg.write_data[DATA_W-1:SRC_W];
    assign exec_event    = (req_reg.opcode == OP_EVENT) && req_reg.line_level;

    // one word and one threshold read port shared by decode and scan
    assign cur_tgt  = (state_reg == ST_SCAN) ? scan_t_reg : exec_tgt;
    assign cur_sel  = (state_reg == ST_SCAN) ? src_reg[SRC_W-1] :
                      (exec_off == OFF_CLAIM) ? req_reg.write_data[SRC_W-1] : exec_off[2];
    assign widx     = {cur_tgt, cur_sel};
    assign word_pe  = pend_reg[widx];
    assign word_en  = en_reg[widx];
    assign word_act = word_pe & word_en;
    assign thr_cur  = thr_reg[cur_tgt];

    assign lines_ext = (TARGET_COUNT + LINE_OUT)'(line_reg);
    assign rsp_load  = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);
    assign scan_last = !scan_all_reg || (scan_t_reg == TGT_W'(TARGET_COUNT - 1));

    always_comb
    begin
        exec_err  = 1'b0;
        exec_scan = 1'b0;
        if ((req_reg.opcode == OP_READ) || (req_reg.opcode == OP_WRITE)) begin
            if (!tgt_ok) begin
                exec_err = 1'b1;
            end
            else begin
                unique case (exec_off)
                    OFF_ENABLE0, OFF_ENABLE1, OFF_PEND0, OFF_PEND1:
                    begin
                        exec_scan = (req_reg.opcode == OP_WRITE);
                    end
                    OFF_CLAIM, OFF_THRESHOLD:
                    begin
                        exec_err  = (req_reg.opcode == OP_WRITE) && data_big;
                        exec_scan = !exec_err &&
                                    ((req_reg.opcode == OP_WRITE) || (exec_off == OFF_CLAIM));
                    end
                    default:
                    begin
                        exec_err = 1'b1;
                    end
                endcase
            end
        end
        else if (exec_event) begin
            exec_scan = 1'b1;
        end
    end

    // shared claim compare unit: one source per cycle
    always_comb
    begin
        scan_fin   = 1'b0;
        scan_claim = '0;
        if (src_reg >= thr_cur) begin
            scan_fin = 1'b1;
        end
        else if (word_act[src_reg[SRC_W-2:0]]) begin
            scan_fin   = 1'b1;
            scan_claim = src_reg;
        end
        else if (src_reg == SRC_LAST) begin
            scan_fin = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = exec_scan ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                if (scan_fin && scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pend_next      = pend_reg;
        en_next        = en_reg;
        thr_next       = thr_reg;
        line_next      = line_reg;
        req_next       = req_reg;
        rd_next        = rd_reg;
        err_next       = err_reg;
        src_next       = src_reg;
        scan_t_next    = scan_t_reg;
        scan_all_next  = scan_all_reg;
        claim_rd_next  = claim_rd_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && !rsp_stall) begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid) begin
                    req_next = req;
                end
            end
            ST_EXEC:
            begin
                rd_next       = '0;
                err_next      = exec_err;
                src_next      = SRC_FIRST;
                scan_t_next   = exec_event ? '0 : exec_tgt;
                scan_all_next = exec_event;
                claim_rd_next = 1'b0;
                if (exec_event) begin
                    for (int t = 0; t < TARGET_COUNT; t++) begin
                        pend_next[WIDX_W'(2 * t) + WIDX_W'(req_reg.irq_number[SRC_W-1])]
                            [req_reg.irq_number[SRC_W-2:0]] = 1'b1;
                    end
                end
                else if (!exec_err && (req_reg.opcode == OP_READ)) begin
                    unique case (exec_off)
                        OFF_ENABLE0, OFF_ENABLE1: rd_next = word_en;
                        OFF_PEND0, OFF_PEND1:     rd_next = word_pe;
                        OFF_THRESHOLD:            rd_next = DATA_W'(thr_cur);
                        default:                  claim_rd_next = 1'b1;
                    endcase
                end
                else if (!exec_err && (req_reg.opcode == OP_WRITE)) begin
                    unique case (exec_off)
                        OFF_ENABLE0, OFF_ENABLE1:
                        begin
                            en_next[widx] = req_reg.write_data;
                        end
                        OFF_PEND0:
                        begin
                            pend_next[widx] = (req_reg.write_data == '0) ? '0 :
                                              (word_pe | (req_reg.write_data & ~DATA_W'(1)));
                        end
                        OFF_PEND1:
                        begin
                            pend_next[widx] = (req_reg.write_data == '0) ? '0 :
                                              (word_pe | req_reg.write_data);
                        end
                        OFF_CLAIM:
                        begin
                            pend_next[widx][req_reg.write_data[SRC_W-2:0]] = 1'b0;
                        end
                        default:
                        begin
                            thr_next[exec_tgt] = req_reg.write_data[SRC_W-1:0];
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_fin) begin
                    line_next[scan_t_reg] = (scan_claim != '0);
                    if (claim_rd_reg) begin
                        rd_next = DATA_W'(scan_claim);
                    end
                    src_next    = SRC_FIRST;
                    scan_t_next = scan_t_reg + TGT_W'(1);
                end
                else begin
                    src_next = src_reg + SRC_W'(1);
                end
            end
            ST_DONE:
            begin
                if (rsp_load) begin
                    rsp_valid_next            = 1'b1;
                    rsp_next.read_data        = rd_reg;
                    rsp_next.access_error     = err_reg;
                    rsp_next.target_irq_lines = lines_ext[LINE_OUT-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            line_reg      <= '0;
            for (int i = 0; i < NUM_WORDS; i++) begin
                pend_reg[i] <= '0;
                en_reg[i]   <= '0;
            end
            for (int i = 0; i < TARGET_COUNT; i++) begin
                thr_reg[i] <= '0;
            end
        end
        else begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            line_reg      <= line_next;
            pend_reg      <= pend_next;
            en_reg        <= en_next;
            thr_reg       <= thr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        rd_reg       <= rd_next;
        err_reg      <= err_next;
        src_reg      <= src_next;
        scan_t_reg   <= scan_t_next;
        scan_all_reg <= scan_all_next;
        claim_rd_reg <= claim_rd_next;
        rsp_reg      <= rsp_next;
    end

    `MTIC_ASSERT_NEXT(a_accept_exec, req_valid && !req_stall, state_reg == ST_EXEC, "item not executed after acceptance")
    `MTIC_ASSERT_NEXT(a_rsp_only_from_done, rsp_valid && !rsp_stall && (state_reg != ST_DONE), !rsp_valid, "result appeared outside completion")
    `MTIC_ASSERT_ALWAYS(a_scan_src_nonzero, (state_reg != ST_SCAN) || (src_reg != '0), "claim scan on source zero")

endmodule
